// ===== rtl/clock_divider_run_step_stop_unit_defines.svh =====
// Assertion macros used by the checker file of the clock divider unit.
// Needs nothing else; include by bare file name.
`ifndef CLOCK_DIVIDER_RUN_STEP_STOP_UNIT_DEFINES_SVH
`define CLOCK_DIVIDER_RUN_STEP_STOP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CDRS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CDRS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cdrs_pkg.sv =====
// Types and constants of the clock divider unit.
// Used by the controller, the datapath, the divider and the top level.
`timescale 1ns / 1ps
`default_nettype none
package cdrs_pkg;

  localparam int DIV_W     = 33;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // request kinds
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_SET    = 3'd1;
  localparam logic [2:0] REQ_STOP   = 3'd2;
  localparam logic [2:0] REQ_STEP   = 3'd3;
  localparam logic [2:0] REQ_RESUME = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_REF_HZ     = 2'd0;
  localparam logic [1:0] REG_MIN_HZ     = 2'd1;
  localparam logic [1:0] REG_STEP_PHASE = 2'd2;

  localparam logic [31:0] REF_HZ_RESET     = 32'd125000000;
  localparam logic [31:0] MIN_HZ_RESET     = 32'd1;
  localparam logic [15:0] STEP_PHASE_RESET = 16'd1250;
  localparam logic [31:0] STORED_HZ_RESET  = 32'd1000000;

  localparam logic DIV_SEL_PERIOD = 1'b0;
  localparam logic DIV_SEL_ACTUAL = 1'b1;

  typedef enum logic [1:0] {
    MODE_STEP     = 2'd0,
    MODE_RUN      = 2'd1,
    MODE_STOPPING = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_PERIOD,
    ST_CALC,
    ST_START_ACT,
    ST_DIV_ACT,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic div_start;
    logic div_sel;
    logic calc;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic out_valid;
    logic div_done;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/clock_divider_run_step_stop_unit.sv =====
// Programmable clock divider with run, stop and step modes: top level.
// Holds the APB registers; depends on cdrs_pkg, cdrs_ctrl and cdrs_dp.
//
// Each input transaction is one reference tick or one request; each yields
// exactly one result transaction carrying the pin level, the mode, an accept
// flag and the actual output frequency. Ticks, stop, step, ignored resumes and
// rejected requests register their result in the cycle after acceptance, so
// ticks stream at one per cycle while the result side keeps up. An accepted
// set or resume runs two passes through the shift-subtract divider (period,
// then rounded actual frequency) with the ST_CALC, ST_START_ACT and ST_FINISH
// sequencing states around them; no input is taken meanwhile, and the next
// one waits longer if the result side holds off the finished result.
// A result waiting in the output register does not block the next input if it
// is taken in the same cycle. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module clock_divider_run_step_stop_unit #(
  parameter int FAST_PERIOD_MAX = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // freq_hz[31:0], step_count[47:32]
  input  wire logic [2:0]  in_tuser,   // req_type[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // clock_level[0], run_mode[2:1], accepted[3],
                                       // actual_hz[35:4], zero[39:36]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [31:0] ref_hz_r, ref_hz_nxt;
  logic [31:0] min_hz_r, min_hz_nxt;
  logic [15:0] step_ph_r, step_ph_nxt;
  logic        wr_en;
  logic [1:0]  reg_idx;

  cdrs_pkg::ctrl_cmd_t cmd;
  cdrs_pkg::dp_sts_t   sts;

  logic        clock_level;
  logic [1:0]  run_mode;
  logic        accepted;
  logic [31:0] actual_hz;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_comb begin
    ref_hz_nxt  = ref_hz_r;
    min_hz_nxt  = min_hz_r;
    step_ph_nxt = step_ph_r;
    if (wr_en) begin
      case (reg_idx)
        cdrs_pkg::REG_REF_HZ:     ref_hz_nxt  = cfg_pwdata;
        cdrs_pkg::REG_MIN_HZ:     min_hz_nxt  = cfg_pwdata;
        cdrs_pkg::REG_STEP_PHASE: step_ph_nxt = cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cdrs_pkg::REG_REF_HZ:     cfg_prdata = ref_hz_r;
      cdrs_pkg::REG_MIN_HZ:     cfg_prdata = min_hz_r;
      cdrs_pkg::REG_STEP_PHASE: cfg_prdata = {16'd0, step_ph_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_hz_r  <= cdrs_pkg::REF_HZ_RESET;
      min_hz_r  <= cdrs_pkg::MIN_HZ_RESET;
      step_ph_r <= cdrs_pkg::STEP_PHASE_RESET;
    end else begin
      ref_hz_r  <= ref_hz_nxt;
      min_hz_r  <= min_hz_nxt;
      step_ph_r <= step_ph_nxt;
    end
  end

  cdrs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  cdrs_dp #(
    .FAST_PERIOD_MAX (FAST_PERIOD_MAX)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .req_type         (in_tuser),
    .freq_hz          (in_tdata[31:0]),
    .step_count       (in_tdata[47:32]),
    .ref_clock_hz     (ref_hz_r),
    .min_hz           (min_hz_r),
    .step_phase_ticks (step_ph_r),
    .out_tready       (out_tready),
    .out_valid        (out_tvalid),
    .clock_level      (clock_level),
    .run_mode         (run_mode),
    .accepted         (accepted),
    .actual_hz        (actual_hz)
  );

  assign out_tdata = {4'd0, actual_hz, accepted, run_mode, clock_level};

endmodule
`default_nettype wire

// ===== rtl/cdrs_div.sv =====
// Shift-subtract unsigned divider, one quotient bit per cycle.
// Depends on cdrs_pkg for its width.
`timescale 1ns / 1ps
`default_nettype none
module cdrs_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [cdrs_pkg::DIV_W-1:0] dividend,
  input  wire logic [cdrs_pkg::DIV_W-1:0] divisor,
  output logic                           done,
  output logic [cdrs_pkg::DIV_W-1:0]     quotient
);

  localparam int W  = cdrs_pkg::DIV_W;
  localparam int CW = cdrs_pkg::DIV_CNT_W;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [W:0]    trial;
  logic          ge;

  assign trial = {rem_r, quo_r[W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      cnt_nxt = CW'(W);
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      // remainder stays below the divisor, so it fits back in W bits
      rem_nxt  = ge ? W'(trial - {1'b0, dvs_r}) : trial[W-1:0];
      quo_nxt  = {quo_r[W-2:0], ge};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/cdrs_ctrl.sv =====
// Controller FSM: input handshake and sequencing of the two divisions of a set or resume.
// Depends on cdrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cdrs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic                out_tready,
  input  wire cdrs_pkg::dp_sts_t   sts,
  output cdrs_pkg::ctrl_cmd_t      cmd
);

  cdrs_pkg::ctrl_state_t state_r, state_nxt;
  logic slot_free;

  assign slot_free = !sts.out_valid || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      cdrs_pkg::ST_IDLE: begin
        in_tready = slot_free;
        cmd.take  = in_tvalid && slot_free;
        if (cmd.take && sts.needs_div) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = cdrs_pkg::DIV_SEL_PERIOD;
          state_nxt     = cdrs_pkg::ST_DIV_PERIOD;
        end
      end
      cdrs_pkg::ST_DIV_PERIOD: begin
        if (sts.div_done) begin
          state_nxt = cdrs_pkg::ST_CALC;
        end
      end
      cdrs_pkg::ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = cdrs_pkg::ST_START_ACT;
      end
      cdrs_pkg::ST_START_ACT: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = cdrs_pkg::DIV_SEL_ACTUAL;
        state_nxt     = cdrs_pkg::ST_DIV_ACT;
      end
      cdrs_pkg::ST_DIV_ACT: begin
        if (sts.div_done) begin
          state_nxt = cdrs_pkg::ST_FINISH;
        end
      end
      cdrs_pkg::ST_FINISH: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = cdrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cdrs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdrs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cdrs_dp.sv =====
// Datapath: wave state, tick and request handling, set math and result register.
// Depends on cdrs_pkg and cdrs_div.
`timescale 1ns / 1ps
`default_nettype none
module cdrs_dp #(
  parameter int FAST_PERIOD_MAX = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cdrs_pkg::ctrl_cmd_t cmd,
  output cdrs_pkg::dp_sts_t        sts,
  input  wire logic [2:0]          req_type,
  input  wire logic [31:0]         freq_hz,
  input  wire logic [15:0]         step_count,
  input  wire logic [31:0]         ref_clock_hz,
  input  wire logic [31:0]         min_hz,
  input  wire logic [15:0]         step_phase_ticks,
  input  wire logic                out_tready,
  output logic                     out_valid,
  output logic                     clock_level,
  output logic [1:0]               run_mode,
  output logic                     accepted,
  output logic [31:0]              actual_hz
);

  localparam int W = cdrs_pkg::DIV_W;

  cdrs_pkg::mode_t mode_r, mode_nxt;
  logic        pin_r, pin_nxt;
  logic [31:0] phase_r, phase_nxt;
  logic [31:0] high_r, high_nxt;
  logic [31:0] low_r, low_nxt;
  logic [31:0] stored_r, stored_nxt;
  logic [15:0] pulses_r, pulses_nxt;
  logic [31:0] cand_r, cand_nxt;
  logic [W-1:0] eff_r, eff_nxt;

  logic        ovalid_r, ovalid_nxt;
  logic        olvl_r, olvl_nxt;
  logic [1:0]  omode_r, omode_nxt;
  logic        oacc_r, oacc_nxt;
  logic [31:0] oact_r, oact_nxt;

  logic [31:0]  test_hz;
  logic         hz_ok;
  logic         needs_div;
  logic [31:0]  step_len;
  logic [W-1:0] div_dividend, div_divisor, quotient;
  logic         div_done;
  logic [31:0]  period;
  logic         fast;
  logic [W-1:0] period_inc;
  logic [31:0]  half;
  logic [15:0]  pulses_dec;
  logic         acc;

  assign test_hz = (req_type == cdrs_pkg::REQ_RESUME) ? stored_r : freq_hz;
  assign hz_ok   = (test_hz != '0) && (test_hz >= min_hz)
                   && (test_hz <= {1'b0, ref_clock_hz[31:1]});
  assign needs_div = hz_ok && ((req_type == cdrs_pkg::REQ_SET)
                   || ((req_type == cdrs_pkg::REQ_RESUME) && (mode_r != cdrs_pkg::MODE_RUN)));
  assign step_len = (step_phase_ticks == '0) ? 32'd1 : {16'd0, step_phase_ticks};

  // period = ceil(ref / hz), then actual = (ref + P/2) / P
  always_comb begin
    if (cmd.div_sel == cdrs_pkg::DIV_SEL_PERIOD) begin
      div_dividend = {1'b0, ref_clock_hz} + {1'b0, test_hz} - W'(1);
      div_divisor  = {1'b0, test_hz};
    end else begin
      div_dividend = {1'b0, ref_clock_hz} + {1'b0, eff_r[W-1:1]};
      div_divisor  = eff_r;
    end
  end

  cdrs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign period     = quotient[31:0];
  assign fast       = period <= 32'(FAST_PERIOD_MAX);
  assign period_inc = {1'b0, period} + W'(1);
  assign half       = period_inc[W-1:1];
  assign pulses_dec = pulses_r - 16'd1;

  always_comb begin
    mode_nxt   = mode_r;
    pin_nxt    = pin_r;
    phase_nxt  = phase_r;
    high_nxt   = high_r;
    low_nxt    = low_r;
    stored_nxt = stored_r;
    pulses_nxt = pulses_r;
    cand_nxt   = cand_r;
    eff_nxt    = eff_r;
    olvl_nxt   = olvl_r;
    omode_nxt  = omode_r;
    oacc_nxt   = oacc_r;
    oact_nxt   = oact_r;
    ovalid_nxt = out_tready ? 1'b0 : ovalid_r;
    acc        = 1'b1;

    if (cmd.take && needs_div) begin
      cand_nxt = test_hz;
    end else if (cmd.take) begin
      case (req_type)
        cdrs_pkg::REQ_TICK: begin
          if (!(mode_r == cdrs_pkg::MODE_STEP && pulses_r == '0)) begin
            if (phase_r > 32'd1) begin
              phase_nxt = phase_r - 32'd1;
            end else if (mode_r == cdrs_pkg::MODE_STEP) begin
              if (pin_r) begin
                pin_nxt   = 1'b0;
                phase_nxt = step_len;
              end else begin
                pulses_nxt = pulses_dec;
                if (pulses_dec != '0) begin
                  pin_nxt   = 1'b1;
                  phase_nxt = step_len;
                end else begin
                  phase_nxt = '0;
                end
              end
            end else if (pin_r) begin
              pin_nxt = 1'b0;
              if (mode_r == cdrs_pkg::MODE_STOPPING) begin
                mode_nxt   = cdrs_pkg::MODE_STEP;
                phase_nxt  = '0;
                pulses_nxt = '0;
              end else begin
                phase_nxt = low_r;
              end
            end else begin
              pin_nxt   = 1'b1;
              phase_nxt = high_r;
            end
          end
        end
        cdrs_pkg::REQ_SET: begin
          acc = 1'b0;  // only a rejected set gets here
        end
        cdrs_pkg::REQ_STOP: begin
          if (mode_r == cdrs_pkg::MODE_RUN) begin
            mode_nxt = cdrs_pkg::MODE_STOPPING;
          end
        end
        cdrs_pkg::REQ_STEP: begin
          if (mode_r != cdrs_pkg::MODE_STEP || pulses_r != '0) begin
            acc = 1'b0;
          end else if (step_count != '0) begin
            pulses_nxt = step_count;
            pin_nxt    = 1'b1;
            phase_nxt  = step_len;
          end
        end
        cdrs_pkg::REQ_RESUME: begin
          // ignored while running, else a rejected resume
          acc = (mode_r == cdrs_pkg::MODE_RUN);
        end
        default: begin
          acc = 1'b0;
        end
      endcase
      ovalid_nxt = 1'b1;
      olvl_nxt   = pin_nxt;
      omode_nxt  = mode_nxt;
      oacc_nxt   = acc;
      oact_nxt   = '0;
    end

    if (cmd.calc) begin
      if (fast) begin
        high_nxt = {1'b0, period[31:1]};
        low_nxt  = period - {1'b0, period[31:1]};
        eff_nxt  = {1'b0, period};
      end else begin
        high_nxt = half;
        low_nxt  = half;
        eff_nxt  = {half, 1'b0};
      end
    end

    if (cmd.commit) begin
      stored_nxt = cand_r;
      mode_nxt   = cdrs_pkg::MODE_RUN;
      pin_nxt    = 1'b0;
      phase_nxt  = low_r;
      pulses_nxt = '0;
      ovalid_nxt = 1'b1;
      olvl_nxt   = 1'b0;
      omode_nxt  = cdrs_pkg::MODE_RUN;
      oacc_nxt   = 1'b1;
      oact_nxt   = quotient[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= cdrs_pkg::MODE_STEP;
      pin_r    <= 1'b0;
      phase_r  <= '0;
      high_r   <= '0;
      low_r    <= '0;
      stored_r <= cdrs_pkg::STORED_HZ_RESET;
      pulses_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      pin_r    <= pin_nxt;
      phase_r  <= phase_nxt;
      high_r   <= high_nxt;
      low_r    <= low_nxt;
      stored_r <= stored_nxt;
      pulses_r <= pulses_nxt;
      ovalid_r <= ovalid_nxt;
    end
    cand_r  <= cand_nxt;
    eff_r   <= eff_nxt;
    olvl_r  <= olvl_nxt;
    omode_r <= omode_nxt;
    oacc_r  <= oacc_nxt;
    oact_r  <= oact_nxt;
  end

  assign sts.needs_div = needs_div;
  assign sts.out_valid = ovalid_r;
  assign sts.div_done  = div_done;

  assign out_valid   = ovalid_r;
  assign clock_level = olvl_r;
  assign run_mode    = omode_r;
  assign accepted    = oacc_r;
  assign actual_hz   = oact_r;

endmodule
`default_nettype wire

// ===== rtl/cdrs_checker.sv =====
// Port-level checker for the clock divider unit, bound to the top level.
// Depends on clock_divider_run_step_stop_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "clock_divider_run_step_stop_unit_defines.svh"
module cdrs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        cfg_pready
);

  // a stalled result keeps its payload
  `CDRS_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // a new input never overwrites a result that is not being taken
  `CDRS_ASSERT_IMP(a_no_overrun, clk, rst_n, in_tvalid && in_tready, !out_tvalid || out_tready, "input taken over a pending result")

  // rejected requests report no frequency
  `CDRS_ASSERT_IMP(a_reject_zero, clk, rst_n, out_tvalid && !out_tdata[3], out_tdata[35:4] == 32'd0, "rejected result with frequency")

  // a reported frequency comes only from a fresh set or resume: running, pin low, accepted
  `CDRS_ASSERT_IMP(a_set_state, clk, rst_n, out_tvalid && (out_tdata[35:4] != 32'd0), (out_tdata[2:1] == 2'd1) && !out_tdata[0] && out_tdata[3], "frequency without a fresh set")

  `CDRS_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, cfg_pready, "pready low")

endmodule

bind clock_divider_run_step_stop_unit cdrs_checker u_cdrs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
`default_nettype wire
